// ===== src/wps_pkg.sv =====
// Package for the weighted phase smoother: sizing constants, datapath
// command and status types. No dependencies.
package wps_pkg;

  // Ring depth; indexing wraps naturally, so keep it a power of two.
  localparam int TAPS   = 8;
  localparam int TapW   = $clog2(TAPS);
  localparam int PhaseW = 16;
  localparam int VarW   = 32;
  localparam int LimW   = 32;

  // Sum of the linear weights TAPS..1.
  localparam int Den    = TAPS * (TAPS + 1) / 2;
  // Bits of |acc| + Den/2.
  localparam int MagW   = PhaseW + $clog2(Den);
  localparam int AccW   = MagW + 1;
  // floor(2^MagW / Den): the quotient estimate is never more than one low.
  localparam int Recip  = (2 ** MagW) / Den;
  localparam int QW     = PhaseW + 1;
  localparam int AvgW   = QW + 1;
  localparam int MulW   = MagW + 1;
  localparam int ProdW  = 2 * MulW;
  localparam int SqW    = 2 * PhaseW + TapW;

  // Plus and minus 180 degrees in 1/128 degree.
  localparam int HalfTurn = 23040;
  localparam int FullTurn = 46080;

  localparam int CfgAddrW = 3;
  localparam logic RegStability = 1'b0;
  localparam logic RegPrecision = 1'b1;

  typedef struct packed {
    logic            load;     // item accepted
    logic            mac;      // weighted sum step
    logic            div_mul;  // reciprocal multiply
    logic            div_fix;  // quotient correction and sign
    logic            sq;       // squared deviation step
    logic            finish;   // form result, update state
    logic [TapW-1:0] k;        // tap counter
  } cmd_t;

  typedef struct packed {
    logic cal;
  } status_t;

endpackage

// ===== src/wps_if.sv =====
// Handshake channel interfaces for the weighted phase smoother.
// Depends on wps_pkg for field widths.
interface wps_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wps_pkg::PhaseW-1:0]     phase_in;
  logic                                  calibrated;

  modport source (output valid, output phase_in, output calibrated, input ready);
  modport sink   (input valid, input phase_in, input calibrated, output ready);
endinterface

interface wps_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wps_pkg::PhaseW-1:0]     phase_out;
  logic        [wps_pkg::VarW-1:0]       variance;
  logic                                  stable;
  logic                                  valid_res;

  modport source (output valid, output phase_out, output variance, output stable,
                  output valid_res, input ready);
  modport sink   (input valid, input phase_out, input variance, input stable,
                  input valid_res, output ready);
endinterface

// ===== src/wps_ctrl.sv =====
// Sequencer for the weighted phase smoother: steps the datapath through
// sum, divide, variance and result phases. Depends on wps_pkg.
module wps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  wps_pkg::status_t status_i,
  output wps_pkg::cmd_t    cmd_o
);
  import wps_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMac  = 3'd1;
  localparam logic [2:0] StDmul = 3'd2;
  localparam logic [2:0] StDfix = 3'd3;
  localparam logic [2:0] StVar  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [TapW-1:0] k_q, k_d;
  logic            out_valid_q, out_valid_d;
  logic            last_tap;

  assign last_tap    = (k_q == TapW'(TAPS - 1));
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.k     = k_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          k_d        = '0;
          state_d    = StMac;
        end
      end
      StMac: begin
        if (!status_i.cal) begin
          state_d = StDone;
        end else begin
          cmd_o.mac = 1'b1;
          k_d       = k_q + 1'b1;
          if (last_tap) begin
            state_d = StDmul;
          end
        end
      end
      StDmul: begin
        cmd_o.div_mul = 1'b1;
        state_d       = StDfix;
      end
      StDfix: begin
        cmd_o.div_fix = 1'b1;
        k_d           = '0;
        state_d       = StVar;
      end
      StVar: begin
        cmd_o.sq = 1'b1;
        k_d      = k_q + 1'b1;
        if (last_tap) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/wps_datapath.sv =====
// Datapath of the weighted phase smoother: history ring, shared multiplier,
// accumulators, divider by reciprocal, result registers. Depends on wps_pkg.
module wps_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wps_pkg::cmd_t                     cmd_i,
  output wps_pkg::status_t                  status_o,
  input  logic signed [wps_pkg::PhaseW-1:0] phase_in_i,
  input  logic                              calibrated_i,
  input  logic        [wps_pkg::LimW-1:0]   stab_limit_i,
  input  logic        [wps_pkg::LimW-1:0]   prec_limit_i,
  output logic signed [wps_pkg::PhaseW-1:0] phase_out_o,
  output logic        [wps_pkg::VarW-1:0]   variance_o,
  output logic                              stable_o,
  output logic                              valid_res_o
);
  import wps_pkg::*;

  logic signed [PhaseW-1:0] hist_q [TAPS];
  logic [TapW-1:0]          slot_q;
  logic                     cal_q;
  logic signed [AccW-1:0]   acc_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AvgW-1:0]   avg_q;
  logic [SqW-1:0]           sq_q;
  logic signed [PhaseW-1:0] last_phase_q;
  logic [VarW-1:0]          last_var_q;
  logic signed [PhaseW-1:0] phase_out_q;
  logic [VarW-1:0]          variance_q;
  logic                     stable_q;
  logic                     valid_res_q;

  logic [TapW-1:0]          rd_idx;
  logic signed [PhaseW-1:0] rd_val;
  logic signed [MulW-1:0]   mul_a, mul_b, diff;
  logic signed [ProdW-1:0]  prod;
  logic                     acc_neg;
  logic signed [AccW-1:0]   acc_abs;
  logic [MagW-1:0]          mag;
  logic [QW-1:0]            q0, q;
  logic [MagW-1:0]          q0_den, rem;
  logic signed [AvgW-1:0]   avg_d;
  logic signed [AvgW-1:0]   wrapped;
  logic [VarW-1:0]          var_new;
  logic                     stable_new;

  assign status_o.cal = cal_q;

  // Newest-first walk for the weighted sum, plain walk for the variance.
  assign rd_idx = cmd_i.mac ? (slot_q - cmd_i.k) : cmd_i.k;
  assign rd_val = hist_q[rd_idx];
  assign diff   = MulW'(rd_val) - MulW'(avg_q);

  assign acc_neg = acc_q[AccW-1];
  assign acc_abs = acc_neg ? -acc_q : acc_q;
  assign mag     = MagW'(acc_abs) + MagW'(Den / 2);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.mac) begin
      mul_a = MulW'(rd_val);
      mul_b = MulW'(TAPS - int'(cmd_i.k));
    end else if (cmd_i.div_mul) begin
      mul_a = signed'({1'b0, mag});
      mul_b = MulW'(Recip);
    end else if (cmd_i.sq) begin
      mul_a = diff;
      mul_b = diff;
    end
  end

  assign prod = mul_a * mul_b;

  // Quotient estimate is at most one low; one compare fixes it.
  assign q0     = prod_q[MagW +: QW];
  assign q0_den = MagW'(q0) * MagW'(Den);
  assign rem    = mag - q0_den;
  assign q      = (rem >= MagW'(Den)) ? q0 + 1'b1 : q0;
  assign avg_d  = acc_neg ? -signed'({1'b0, q}) : signed'({1'b0, q});

  always_comb begin
    wrapped = avg_q;
    if (avg_q > AvgW'(HalfTurn)) begin
      wrapped = avg_q - AvgW'(FullTurn);
    end else if (avg_q < -AvgW'(HalfTurn)) begin
      wrapped = avg_q + AvgW'(FullTurn);
    end
  end

  assign var_new    = VarW'(sq_q >> TapW);
  assign stable_new = var_new < stab_limit_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        hist_q[i] <= '0;
      end
      slot_q       <= '0;
      last_phase_q <= '0;
      last_var_q   <= '0;
    end else begin
      if (cmd_i.load && calibrated_i) begin
        hist_q[slot_q] <= phase_in_i;
      end
      if (cmd_i.finish && cal_q) begin
        slot_q       <= slot_q + 1'b1;
        last_phase_q <= wrapped[PhaseW-1:0];
        last_var_q   <= var_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cal_q <= calibrated_i;
      acc_q <= '0;
      sq_q  <= '0;
    end
    if (cmd_i.mac) begin
      acc_q <= acc_q + AccW'(prod);
    end
    if (cmd_i.div_mul) begin
      prod_q <= prod;
    end
    if (cmd_i.div_fix) begin
      avg_q <= avg_d;
    end
    if (cmd_i.sq) begin
      sq_q <= sq_q + prod[SqW-1:0];
    end
    if (cmd_i.finish) begin
      if (cal_q) begin
        phase_out_q <= wrapped[PhaseW-1:0];
        variance_q  <= var_new;
        stable_q    <= stable_new;
        valid_res_q <= stable_new && (var_new <= prec_limit_i);
      end else begin
        phase_out_q <= last_phase_q;
        variance_q  <= last_var_q;
        stable_q    <= 1'b0;
        valid_res_q <= 1'b0;
      end
    end
  end

  assign phase_out_o = phase_out_q;
  assign variance_o  = variance_q;
  assign stable_o    = stable_q;
  assign valid_res_o = valid_res_q;

endmodule

// ===== src/weighted_phase_smoother.sv =====
// Top level of the weighted phase smoother: APB register file, sequencer and
// datapath. Depends on wps_pkg, wps_if, wps_ctrl and wps_datapath.
//
// Each item carries a phase reading in 1/128 degree and a calibrated flag. A
// calibrated reading enters an eight-entry ring; the block then forms the
// linearly weighted average (newest weight 8 down to oldest weight 1, divided
// by 36, rounded to nearest with ties away from zero), the mean squared
// deviation of the ring from that average (1/16384 square degree), and the
// average wrapped into plus or minus 180 degrees. stable is set when the
// variance is below the stability limit, valid_res when it is also at or
// below the precision limit. An uncalibrated item changes nothing and returns
// the previous phase and variance with both flags low. One result leaves per
// item. A calibrated item is accepted, then takes the weighted sum through
// the shared multiplier, the divide by reciprocal, the squared deviations
// through the same multiplier and the forming of the result, in that order.
// An uncalibrated item goes from acceptance straight to forming the result.
// The result waits in an output register, so the next item is accepted while
// it is still pending. Limits sit at byte addresses 0 (stability) and 4
// (precision); write them only while the block is idle.
module weighted_phase_smoother (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  wps_in_if.sink                       in_i,
  wps_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wps_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import wps_pkg::*;

  logic [LimW-1:0] stab_limit_q;
  logic [LimW-1:0] prec_limit_q;
  logic            cfg_wr;
  cmd_t            cmd;
  status_t         status;

  // Register file: pready is tied high, index taken from address bit 2.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stab_limit_q <= LimW'(409600);
      prec_limit_q <= LimW'(102400);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegStability: stab_limit_q <= pwdata;
        RegPrecision: prec_limit_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegStability: prdata = stab_limit_q;
      RegPrecision: prdata = prec_limit_q;
      default:      prdata = '0;
    endcase
  end

  // Sequencer: holds the input off while an item is in flight.
  wps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: ring, shared multiplier, result registers.
  wps_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .phase_in_i   (in_i.phase_in),
    .calibrated_i (in_i.calibrated),
    .stab_limit_i (stab_limit_q),
    .prec_limit_i (prec_limit_q),
    .phase_out_o  (out_o.phase_out),
    .variance_o   (out_o.variance),
    .stable_o     (out_o.stable),
    .valid_res_o  (out_o.valid_res)
  );

endmodule
